// ----- rtl/bbp_pkg.sv -----
// Package for the bimodal branch predictor with target buffer.
// Request and result payload types, controller/datapath command and status types, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbp_pkg;

  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 32;
  localparam int CTR_W      = 2;
  localparam int DIGIT_W    = 8;
  localparam int DIGITS     = ADDR_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(DIGITS);
  localparam int ROW_W      = CTR_W + ADDR_W;

  localparam logic [CTR_W-1:0] CTR_STRONG_NT  = 2'd0;
  localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic [ADDR_W-1:0] branch_target;
    logic              taken;
  } bbp_in_t;

  typedef struct packed {
    logic              predicted_taken;
    logic [ADDR_W-1:0] predicted_target;
    logic              direction_miss;
    logic              target_miss;
    logic [CNT_W-1:0]  correct_count;
    logic [CNT_W-1:0]  wrong_count;
  } bbp_out_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic clr_wr;
    logic upd;
  } bbp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
  } bbp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/bbp_ctrl.sv -----
// Sequencer of the branch predictor: table clear, index reduction, read, update.
// Depends on bbp_pkg; drives bbp_datapath through bbp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module bbp_ctrl
  import bbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire bbp_sts_t sts,
  output bbp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_UPD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   upd_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign upd_fire  = (state_r == S_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.mod_step = 1'b0;
    cmd.clr_wr   = 1'b0;
    cmd.upd      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_fire) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (upd_fire)  out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bbp_datapath.sv -----
// Datapath of the branch predictor: index reduction, entry table, counters, result register.
// Depends on bbp_pkg; commanded by bbp_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bbp_datapath
  import bbp_pkg::*;
#(
  parameter int ENTRIES = 1024
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire bbp_in_t  in_data,
  input  wire bbp_cmd_t cmd,
  output bbp_sts_t      sts,
  output bbp_out_t      out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W:0]   ENTRIES_W = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

  logic [ROW_W-1:0] mem_r [ENTRIES];
  logic [ROW_W-1:0] rd_data_r;
  logic [ROW_W-1:0] wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  logic [ADDR_W-1:0]    addr_sh_r;
  logic [ADDR_W-1:0]    target_r;
  logic                 taken_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r;
  logic [IDX_W-1:0]     clr_idx_r;
  logic [CNT_W-1:0]     hits_r, hits_nxt;
  logic [CNT_W-1:0]     misses_r, misses_nxt;
  bbp_out_t             out_data_r, out_data_nxt;

  logic [CTR_W-1:0]  ctr, ctr_new;
  logic [ADDR_W-1:0] stored;
  logic              pred, dmiss, tmiss;

  assign sts.clr_done = (clr_idx_r == LAST_IDX);
  assign sts.mod_done = (dig_cnt_r == DIG_CNT_W'(DIGITS - 1));
  assign out_data     = out_data_r;

  // one address digit per cycle, most significant first
  always_comb begin
    logic [IDX_W:0] acc;
    acc = {1'b0, idx_r};
    for (int i = 0; i < DIGIT_W; i++) begin
      acc = {acc[IDX_W-1:0], addr_sh_r[ADDR_W-1-i]};
      if (acc >= ENTRIES_W) acc = acc - ENTRIES_W;
    end
    idx_nxt = acc[IDX_W-1:0];
  end

  always_comb begin
    ctr    = rd_data_r[ROW_W-1 -: CTR_W];
    stored = rd_data_r[ADDR_W-1:0];
    pred   = ctr[CTR_W-1];
    dmiss  = pred ^ taken_r;
    tmiss  = (stored != target_r);
    ctr_new = ctr;
    if (taken_r) begin
      if (ctr != CTR_MAX) ctr_new = ctr + 1'b1;
    end else begin
      if (ctr != CTR_STRONG_NT) ctr_new = ctr - 1'b1;
    end
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (dmiss) begin
      if (misses_r != CNT_MAX) misses_nxt = misses_r + 1'b1;
    end else begin
      if (hits_r != CNT_MAX) hits_nxt = hits_r + 1'b1;
    end
    out_data_nxt.predicted_taken  = pred;
    out_data_nxt.predicted_target = stored;
    out_data_nxt.direction_miss   = dmiss;
    out_data_nxt.target_miss      = tmiss;
    out_data_nxt.correct_count    = hits_nxt;
    out_data_nxt.wrong_count      = misses_nxt;
  end

  always_comb begin
    wr_en   = cmd.clr_wr || cmd.upd;
    wr_addr = cmd.clr_wr ? clr_idx_r : idx_r;
    wr_data = cmd.clr_wr ? {CTR_WEAK_TAKEN, {ADDR_W{1'b0}}} : {ctr_new, target_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      dig_cnt_r <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
    end else begin
      if (cmd.clr_wr && !sts.clr_done) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.load)          dig_cnt_r <= '0;
      else if (cmd.mod_step) dig_cnt_r <= dig_cnt_r + 1'b1;
      if (cmd.upd) begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_sh_r <= in_data.branch_address;
      target_r  <= in_data.branch_target;
      taken_r   <= in_data.taken;
      idx_r     <= '0;
    end else if (cmd.mod_step) begin
      addr_sh_r <= addr_sh_r << DIGIT_W;
      idx_r     <= idx_nxt;
    end
    if (cmd.upd) out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/bimodal_branch_predictor_btb.sv -----
// Bimodal 2-bit branch predictor with branch target buffer, top level.
// Depends on bbp_pkg, bbp_ctrl and bbp_datapath.
//
// Usage:
//   One request per resolved conditional branch on in_valid/in_ready/in_data
//   (address, target, taken). One result per request on out_valid/out_ready/
//   out_data: prediction and stored target read before the update, miss flags
//   and the saturating correct/wrong direction counts including this branch.
//   Entry index is branch_address mod ENTRIES, reduced one 8-bit digit per
//   cycle. The entry table has a registered read port.
//   After acceptance the index is reduced, the entry read, then the result
//   registered with the update. A new request is accepted only after the
//   index reduction, table read and read-modify-write update of the last one.
//   Reset: synchronous, active low. After reset the table is cleared to weakly
//   taken and zero target, one entry per cycle; in_ready stays low during
//   that pass.
//   Stall: a pending result stays in the output register; one further request
//   is accepted and processed, then held before update until the output frees.
`timescale 1ns / 1ps
`default_nettype none
module bimodal_branch_predictor_btb
  import bbp_pkg::*;
#(
  parameter int ENTRIES = 1024
)(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire bbp_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output bbp_out_t     out_data
);

  bbp_cmd_t cmd;
  bbp_sts_t sts;

  bbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbp_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
